>>> hdl/traffic_light_with_walk_button_core_macros.svh
// Assertion macros for the traffic light core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef TRAFFIC_LIGHT_WITH_WALK_BUTTON_CORE_MACROS_SVH
`define TRAFFIC_LIGHT_WITH_WALK_BUTTON_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TLWB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TLWB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tlwb_pkg.sv
// Shared constants, types and functions for the traffic light core.
// No dependencies.
package tlwb_pkg;

    localparam int TIMER_WIDTH  = 16;
    localparam int STABLE_WIDTH = 8;

    localparam int CFG_W   = 16;
    localparam int DEB_W   = 8;
    localparam int IDX_W   = 3;
    localparam int PHASE_W = 3;

    localparam logic [IDX_W-1:0] REG_GREEN_TIME      = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORANGE_TIME     = 3'd1;
    localparam logic [IDX_W-1:0] REG_RED_TIME        = 3'd2;
    localparam logic [IDX_W-1:0] REG_RED_ORANGE_TIME = 3'd3;
    localparam logic [IDX_W-1:0] REG_WALK_DELAY      = 3'd4;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE_TICKS  = 3'd5;

    localparam logic [CFG_W-1:0] RST_GREEN_TIME      = 16'd5000;
    localparam logic [CFG_W-1:0] RST_ORANGE_TIME     = 16'd2000;
    localparam logic [CFG_W-1:0] RST_RED_TIME        = 16'd7000;
    localparam logic [CFG_W-1:0] RST_RED_ORANGE_TIME = 16'd1500;
    localparam logic [CFG_W-1:0] RST_WALK_DELAY      = 16'd500;
    localparam logic [DEB_W-1:0] RST_DEBOUNCE_TICKS  = 8'd50;

    localparam logic [PHASE_W-1:0] PH_GREEN  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HOLD   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ORANGE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RED    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_REDOR  = 3'd4;

    typedef struct packed {
        logic level;
        logic rise;
    } t_deb_status;

    function automatic logic [PHASE_W-1:0] phase_after(input logic [PHASE_W-1:0] p);
        logic [PHASE_W-1:0] q;
        case (p)
            PH_ORANGE: q = PH_RED;
            PH_RED:    q = PH_REDOR;
            PH_REDOR:  q = PH_GREEN;
            default:   q = PH_ORANGE;
        endcase
        return q;
    endfunction

endpackage

>>> hdl/tlwb_if.sv
// Valid/ready channel interfaces for tick input and light result.
// Depends on tlwb_pkg.
interface tlwb_in_if import tlwb_pkg::*; ();
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface tlwb_out_if import tlwb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               green_light;
    logic               orange_light;
    logic               red_light;
    logic [PHASE_W-1:0] light_phase;
    logic               clean_button;

    modport source (output valid, output green_light, output orange_light,
                    output red_light, output light_phase, output clean_button,
                    input ready);
    modport sink (input valid, input green_light, input orange_light,
                  input red_light, input light_phase, input clean_button,
                  output ready);
endinterface

>>> hdl/tlwb_debounce.sv
// Button debouncer: stable-level counter with saturating count.
// Depends on tlwb_pkg.
module tlwb_debounce import tlwb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_sample,
    input  logic [DEB_W-1:0] i_threshold,
    output t_deb_status      o_status
);
    localparam int SCMP_W = (STABLE_WIDTH > DEB_W) ? STABLE_WIDTH : DEB_W;
    localparam logic [STABLE_WIDTH-1:0] SMAX = {STABLE_WIDTH{1'b1}};

    logic [STABLE_WIDTH-1:0] r_count, n_count;
    logic                    r_last;
    logic                    r_level, n_level;
    logic                    take;

    always_comb begin
        if (i_sample != r_last) begin
            n_count = '0;
        end else if (r_count != SMAX) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
        take    = (SCMP_W'(n_count) > SCMP_W'(i_threshold)) && (i_sample != r_level);
        n_level = (i_step && take) ? i_sample : r_level;
        o_status.level = n_level;
        o_status.rise  = i_step && take && i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= 1'b0;
            r_level <= 1'b0;
        end else if (i_step) begin
            r_count <= n_count;
            r_last  <= i_sample;
            r_level <= n_level;
        end
    end
endmodule

>>> hdl/traffic_light_with_walk_button_core.sv
// Traffic light controller with debounced pedestrian walk button.
// Depends on tlwb_pkg, tlwb_if, tlwb_debounce and the assertion macro header.
//
// Usage:
//   i_item   : one transfer per millisecond tick, carrying the raw button level.
//   o_result : one transfer per tick with the lamps, phase code and debounced
//              button level as they stand after that tick.
//   Config   : i_cfg_we/i_cfg_idx/i_cfg_data write the phase durations, walk
//              delay and debounce threshold; write only while no tick is in
//              flight. Unknown indexes are ignored.
// Latency: a result is valid the cycle after its tick transfer.
// Throughput: one tick per cycle while no result is held or o_result.ready
//   is high; the tick's whole update is counter increments and compares
//   between state and result registers, with no register inside the state loop.
// Reset: synchronous, active low. Phase goes to green, timers and debouncer
//   clear, the result register empties, config returns to defaults.
// Stall: the result register holds while o_result.ready is low; a new tick
//   is taken in the same cycle the held result is transferred, and not
//   otherwise.
`include "traffic_light_with_walk_button_core_macros.svh"

module traffic_light_with_walk_button_core import tlwb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    tlwb_in_if.sink          i_item,
    tlwb_out_if.source       o_result
);
    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    logic [CFG_W-1:0] r_green_time, r_orange_time, r_red_time;
    logic [CFG_W-1:0] r_red_orange_time, r_walk_delay;
    logic [DEB_W-1:0] r_debounce_ticks;

    logic [PHASE_W-1:0]     r_phase, n_phase, mid_phase;
    logic [TIMER_WIDTH-1:0] r_timer, n_timer, mid_timer, inc_timer;
    logic [CFG_W-1:0]       cur_len;
    logic                   phase_end;

    logic                   r_out_valid;
    logic                   r_green, r_orange, r_red, r_clean;
    logic [PHASE_W-1:0]     r_out_phase;

    logic                   accept;
    logic                   hold;
    t_deb_status            deb;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;
    assign hold         = (r_phase == PH_HOLD);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_time      <= RST_GREEN_TIME;
            r_orange_time     <= RST_ORANGE_TIME;
            r_red_time        <= RST_RED_TIME;
            r_red_orange_time <= RST_RED_ORANGE_TIME;
            r_walk_delay      <= RST_WALK_DELAY;
            r_debounce_ticks  <= RST_DEBOUNCE_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GREEN_TIME:      r_green_time      <= i_cfg_data;
                REG_ORANGE_TIME:     r_orange_time     <= i_cfg_data;
                REG_RED_TIME:        r_red_time        <= i_cfg_data;
                REG_RED_ORANGE_TIME: r_red_orange_time <= i_cfg_data;
                REG_WALK_DELAY:      r_walk_delay      <= i_cfg_data;
                REG_DEBOUNCE_TICKS:  r_debounce_ticks  <= i_cfg_data[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    tlwb_debounce u_debounce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept && !hold),
        .i_sample    (i_item.button_level),
        .i_threshold (r_debounce_ticks),
        .o_status    (deb)
    );

    always_comb begin
        mid_phase = r_phase;
        mid_timer = r_timer;
        if (deb.rise && (r_phase == PH_GREEN)) begin
            mid_phase = PH_HOLD;
            mid_timer = '0;
        end

        case (mid_phase)
            PH_HOLD:   cur_len = r_walk_delay;
            PH_ORANGE: cur_len = r_orange_time;
            PH_RED:    cur_len = r_red_time;
            PH_REDOR:  cur_len = r_red_orange_time;
            default:   cur_len = r_green_time;
        endcase

        inc_timer = (mid_timer != TMAX) ? mid_timer + 1'b1 : mid_timer;
        phase_end = (CMP_W'(inc_timer) >= CMP_W'(cur_len)) || (inc_timer == TMAX);

        if (phase_end) begin
            n_phase = phase_after(mid_phase);
            n_timer = '0;
        end else begin
            n_phase = mid_phase;
            n_timer = inc_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_GREEN;
            r_timer <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_green     <= (n_phase == PH_GREEN) || (n_phase == PH_HOLD) || (n_phase > PH_REDOR);
            r_orange    <= (n_phase == PH_ORANGE) || (n_phase == PH_REDOR);
            r_red       <= (n_phase == PH_RED) || (n_phase == PH_REDOR);
            r_out_phase <= n_phase;
            r_clean     <= deb.level;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.green_light  = r_green;
    assign o_result.orange_light = r_orange;
    assign o_result.red_light    = r_red;
    assign o_result.light_phase  = r_out_phase;
    assign o_result.clean_button = r_clean;

    `TLWB_ASSERT_NOW(a_phase_legal, i_clk, i_rst_n, 1'b1,
        (r_phase == PH_GREEN) || (r_phase == PH_HOLD) || (r_phase == PH_ORANGE) ||
        (r_phase == PH_RED) || (r_phase == PH_REDOR), "phase register out of range")
    `TLWB_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, r_out_valid,
        "accepted tick did not produce a result")
    `TLWB_ASSERT_NOW(a_lamps_exclusive, i_clk, i_rst_n, r_out_valid,
        !(r_green && (r_red || r_orange)), "green lit together with red or orange")
    `TLWB_ASSERT_NEXT(a_hold_ignores_button, i_clk, i_rst_n, accept && hold,
        r_clean == $past(r_clean) || !$past(r_out_valid),
        "debounced level moved during green hold")
    // hold entry counts its first tick, so only other phase changes clear the timer
    `TLWB_ASSERT_NOW(a_timer_clear_on_change, i_clk, i_rst_n,
        !$stable(r_phase) && (r_phase != PH_HOLD),
        r_timer == '0, "phase changed without timer clear")
endmodule
